// File: src/tdor_pkg.sv
// Package for the torus dimension-order route walker.
// Holds the beat payload types, configuration types, state codes and sizes.
// No dependencies.
`default_nettype none

package tdor_pkg;

  localparam int NUM_DIMS     = 5;
  localparam int MAX_DIM_SIZE = 8;
  localparam int ORDER_SLOTS  = 5;
  localparam int COORD_W      = 3;
  localparam int SIZE_W       = 4;
  localparam int T_W          = 6;
  localparam int HOP_W        = 6;
  localparam int ORDER_W      = 15;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_A      = 3'd0,
    REG_SIZE_B      = 3'd1,
    REG_SIZE_C      = 3'd2,
    REG_SIZE_D      = 3'd3,
    REG_SIZE_E      = 3'd4,
    REG_WRAP_MASK   = 3'd5,
    REG_ROUTE_ORDER = 3'd6
  } tdor_reg_t;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 4'd1;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 15'd18056;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_STEP,
    S_FLUSH
  } tdor_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_a;
    logic [COORD_W-1:0] src_b;
    logic [COORD_W-1:0] src_c;
    logic [COORD_W-1:0] src_d;
    logic [COORD_W-1:0] src_e;
    logic [COORD_W-1:0] dst_a;
    logic [COORD_W-1:0] dst_b;
    logic [COORD_W-1:0] dst_c;
    logic [COORD_W-1:0] dst_d;
    logic [COORD_W-1:0] dst_e;
    logic [T_W-1:0]     dst_t;
  } tdor_in_t;

  typedef struct packed {
    logic [HOP_W-1:0]   hop_number;
    logic [2:0]         hop_dim;
    logic [COORD_W-1:0] at_a;
    logic [COORD_W-1:0] at_b;
    logic [COORD_W-1:0] at_c;
    logic [COORD_W-1:0] at_d;
    logic [COORD_W-1:0] at_e;
    logic [T_W-1:0]     at_t;
    logic               last_hop;
  } tdor_out_t;

  typedef struct packed {
    logic [NUM_DIMS-1:0][SIZE_W-1:0] size;
    logic [NUM_DIMS-1:0]             wrap_mask;
    logic [ORDER_W-1:0]              route_order;
  } tdor_cfg_t;

  // Result of the shared arithmetic unit.
  typedef struct packed {
    logic               skip;
    logic [COORD_W-1:0] hops;
    logic               plus;
    logic [COORD_W-1:0] next_c;
  } tdor_unit_t;

endpackage

`default_nettype wire

// File: src/torus_dimension_order_route.sv
// Dimension-order route walker for a five-dimensional mesh or torus: an accepted
// source/destination beat produces one result beat per single-step hop, in the
// dimension order held in route_order, with last_hop marking the final beat. One
// shared ring unit is stepped by a sequencer through an accept step, a setup step per
// order slot plus one, a step per hop and a flush step, so a route occupies the
// block until it is done; in_stall stays high for that time and output
// stalls stretch it. Configuration writes are always taken (cfg_ready is high) and
// must only be issued while no route is in progress. Depends on tdor_pkg, tdor_walk.
`default_nettype none

module torus_dimension_order_route (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tdor_pkg::tdor_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tdor_pkg::tdor_out_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tdor_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tdor_pkg::ORDER_W-1:0]      cfg_data
);
  import tdor_pkg::*;

  tdor_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (tdor_reg_t'(cfg_index))
        REG_SIZE_A:      cfg_nxt.size[0]     = cfg_data[SIZE_W-1:0];
        REG_SIZE_B:      cfg_nxt.size[1]     = cfg_data[SIZE_W-1:0];
        REG_SIZE_C:      cfg_nxt.size[2]     = cfg_data[SIZE_W-1:0];
        REG_SIZE_D:      cfg_nxt.size[3]     = cfg_data[SIZE_W-1:0];
        REG_SIZE_E:      cfg_nxt.size[4]     = cfg_data[SIZE_W-1:0];
        REG_WRAP_MASK:   cfg_nxt.wrap_mask   = cfg_data[NUM_DIMS-1:0];
        REG_ROUTE_ORDER: cfg_nxt.route_order = cfg_data;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size        <= {NUM_DIMS{SIZE_RESET}};
      cfg_r.wrap_mask   <= '0;
      cfg_r.route_order <= ORDER_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tdor_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: src/tdor_unit.sv
// Shared ring arithmetic for one dimension: distance, direction and single step.
// Depends on tdor_pkg.
`default_nettype none

module tdor_unit (
  input  wire logic [tdor_pkg::COORD_W-1:0] cur_c,
  input  wire logic [tdor_pkg::COORD_W-1:0] dst_c,
  input  wire logic [tdor_pkg::SIZE_W-1:0]  size_raw,
  input  wire logic                         wrap,
  input  wire logic                         step_plus,
  output tdor_pkg::tdor_unit_t              res
);
  import tdor_pkg::*;

  logic [SIZE_W-1:0]  sz;
  logic [COORD_W-1:0] delta;
  logic [SIZE_W-1:0]  delta2;
  logic [SIZE_W-1:0]  cur_ext;
  logic [SIZE_W-1:0]  dst_ext;
  logic [SIZE_W-1:0]  sz_minus_dist;
  logic [SIZE_W-1:0]  sz_minus_one;

  always_comb begin
    if (size_raw == '0) begin
      sz = SIZE_W'(1);
    end else if (size_raw > SIZE_W'(MAX_DIM_SIZE)) begin
      sz = SIZE_W'(MAX_DIM_SIZE);
    end else begin
      sz = size_raw;
    end

    cur_ext       = {1'b0, cur_c};
    dst_ext       = {1'b0, dst_c};
    delta         = (dst_c > cur_c) ? (dst_c - cur_c) : (cur_c - dst_c);
    delta2        = {delta, 1'b0};
    sz_minus_dist = sz - {1'b0, delta};
    sz_minus_one  = sz - SIZE_W'(1);

    res.skip = (cur_c == dst_c) || (wrap && ((cur_ext >= sz) || (dst_ext >= sz)));

    // A torus dimension goes the short way; an exact half ring breaks the tie on parity.
    if (wrap && (delta2 > sz)) begin
      res.hops = sz_minus_dist[COORD_W-1:0];
      res.plus = (dst_c < cur_c);
    end else if (wrap && (delta2 == sz)) begin
      res.hops = delta;
      res.plus = ~cur_c[0];
    end else begin
      res.hops = delta;
      res.plus = (dst_c > cur_c);
    end

    if (step_plus) begin
      if (wrap && ((cur_ext + SIZE_W'(1)) == sz)) begin
        res.next_c = '0;
      end else begin
        res.next_c = cur_c + COORD_W'(1);
      end
    end else begin
      if (wrap && (cur_c == '0)) begin
        res.next_c = sz_minus_one[COORD_W-1:0];
      end else begin
        res.next_c = cur_c - COORD_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/tdor_walk.sv
// Route sequencer: walks the order slots, steps the shared unit once per hop
// and hands hop beats through a holding stage and an output register.
// Depends on tdor_pkg and tdor_unit.
`default_nettype none

module tdor_walk (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tdor_pkg::tdor_cfg_t  cfg,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tdor_pkg::tdor_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tdor_pkg::tdor_out_t       out_data
);
  import tdor_pkg::*;

  tdor_state_t                     state_r, state_nxt;
  logic [NUM_DIMS-1:0][COORD_W-1:0] cur_r, cur_nxt;
  logic [NUM_DIMS-1:0][COORD_W-1:0] dst_r, dst_nxt;
  logic [T_W-1:0]                  t_r, t_nxt;
  logic [2:0]                      slot_r, slot_nxt;
  logic [2:0]                      dim_r, dim_nxt;
  logic [COORD_W-1:0]              hops_r, hops_nxt;
  logic                            plus_r, plus_nxt;
  logic [HOP_W-1:0]                hop_cnt_r, hop_cnt_nxt;
  tdor_out_t                       pend_r, pend_nxt;
  logic                            pend_vld_r, pend_vld_nxt;
  tdor_out_t                       out_r, out_nxt;
  logic                            out_vld_r, out_vld_nxt;

  logic [2:0]                      order_dim;
  logic [2:0]                      sel_dim;
  logic                            dim_ok;
  logic [2:0]                      idx;
  logic                            out_free;
  logic                            can_gen;
  logic [NUM_DIMS-1:0][COORD_W-1:0] moved;
  tdor_unit_t                      ures;

  assign order_dim = (slot_r < 3'(ORDER_SLOTS)) ? cfg.route_order[slot_r*3 +: 3] : '0;
  assign sel_dim   = (state_r == S_SETUP) ? order_dim : dim_r;
  assign dim_ok    = (sel_dim < 3'(NUM_DIMS));
  assign idx       = dim_ok ? sel_dim : '0;

  tdor_unit u_unit (
    .cur_c     (cur_r[idx]),
    .dst_c     (dst_r[idx]),
    .size_raw  (cfg.size[idx]),
    .wrap      (cfg.wrap_mask[idx]),
    .step_plus (plus_r),
    .res       (ures)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign can_gen  = !pend_vld_r || out_free;

  always_comb begin
    for (int k = 0; k < NUM_DIMS; k++) begin
      moved[k] = (3'(k) == dim_r) ? ures.next_c : cur_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_r      <= '0;
      slot_r     <= '0;
      hops_r     <= '0;
      hop_cnt_r  <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      slot_r     <= slot_nxt;
      hops_r     <= hops_nxt;
      hop_cnt_r  <= hop_cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r  <= dst_nxt;
    t_r    <= t_nxt;
    dim_r  <= dim_nxt;
    plus_r <= plus_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    dst_nxt      = dst_r;
    t_nxt        = t_r;
    slot_nxt     = slot_r;
    dim_nxt      = dim_r;
    hops_nxt     = hops_r;
    plus_nxt     = plus_r;
    hop_cnt_nxt  = hop_cnt_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_nxt[0]  = in_data.src_a;
          cur_nxt[1]  = in_data.src_b;
          cur_nxt[2]  = in_data.src_c;
          cur_nxt[3]  = in_data.src_d;
          cur_nxt[4]  = in_data.src_e;
          dst_nxt[0]  = in_data.dst_a;
          dst_nxt[1]  = in_data.dst_b;
          dst_nxt[2]  = in_data.dst_c;
          dst_nxt[3]  = in_data.dst_d;
          dst_nxt[4]  = in_data.dst_e;
          t_nxt       = in_data.dst_t;
          slot_nxt    = '0;
          hop_cnt_nxt = '0;
          state_nxt   = S_SETUP;
        end
      end
      S_SETUP: begin
        if (slot_r == 3'(ORDER_SLOTS)) begin
          slot_nxt  = '0;
          state_nxt = S_FLUSH;
        end else begin
          slot_nxt = slot_r + 3'd1;
          if (dim_ok && !ures.skip) begin
            dim_nxt   = sel_dim;
            hops_nxt  = ures.hops;
            plus_nxt  = ures.plus;
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (can_gen) begin
          cur_nxt             = moved;
          hop_cnt_nxt         = hop_cnt_r + HOP_W'(1);
          pend_nxt.hop_number = hop_cnt_r + HOP_W'(1);
          pend_nxt.hop_dim    = dim_r;
          pend_nxt.at_a       = moved[0];
          pend_nxt.at_b       = moved[1];
          pend_nxt.at_c       = moved[2];
          pend_nxt.at_d       = moved[3];
          pend_nxt.at_e       = moved[4];
          pend_nxt.at_t       = t_r;
          pend_nxt.last_hop   = 1'b0;
          pend_vld_nxt        = 1'b1;
          // A newer hop exists, so the held one cannot be the last of the route.
          if (pend_vld_r) begin
            out_nxt          = pend_r;
            out_nxt.last_hop = 1'b0;
            out_vld_nxt      = 1'b1;
          end
          hops_nxt = hops_r - COORD_W'(1);
          if (hops_r == COORD_W'(1)) begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt          = pend_r;
          out_nxt.last_hop = 1'b1;
          out_vld_nxt      = 1'b1;
          pend_vld_nxt     = 1'b0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: src/tdor_checker.sv
// Port-level checks for the route walker, bound to the top level.
// Depends on tdor_pkg and torus_dimension_order_route.
`default_nettype none

module tdor_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire tdor_pkg::tdor_out_t out_data
);
  import tdor_pkg::*;

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // The walker is busy right after it takes a route request.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a route was starting");

  // While a beat that is not the last one is shown, the route is still in progress.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_hop |-> in_stall)
    else $error("block idle before the final hop was delivered");

  // Every result names a real dimension and a hop ordinal from one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hop_number != '0) && (out_data.hop_dim < 3'(NUM_DIMS)))
    else $error("malformed hop beat");

endmodule

bind torus_dimension_order_route tdor_checker u_tdor_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/tdor_hop_check.sv
`timescale 1ns / 1ps
// Hop checker for the torus dimension-order route walker: watches the route,
// result and register channels, predicts every hop beat and compares it.
// Depends on tdor_pkg.
module tdor_hop_check
  import tdor_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  tdor_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  tdor_out_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ORDER_W-1:0]   cfg_data,
  output int        pending_hops,
  output int        fail_count
);

  logic [SIZE_W-1:0]   ring_size [NUM_DIMS];
  logic [NUM_DIMS-1:0] wrap_dims;
  logic [ORDER_W-1:0]  route_order;
  tdor_out_t           hop_q [$];
  int                  fails = 0;

  // Walks the route slot by slot and queues one beat per single-step hop.
  function automatic void plan_route(tdor_in_t req);
    logic [COORD_W-1:0] cur [NUM_DIMS];
    logic [COORD_W-1:0] goal [NUM_DIMS];
    tdor_out_t beat;
    bit held, ring, plus;
    int count, dim, c, d, span, eff, steps;
    cur[0] = req.src_a;  cur[1] = req.src_b;  cur[2] = req.src_c;
    cur[3] = req.src_d;  cur[4] = req.src_e;
    goal[0] = req.dst_a; goal[1] = req.dst_b; goal[2] = req.dst_c;
    goal[3] = req.dst_d; goal[4] = req.dst_e;
    held = 0;
    count = 0;
    beat = '0;
    for (int slot = 0; slot < ORDER_SLOTS; slot++) begin
      dim = route_order[3*slot +: 3];
      if (dim >= NUM_DIMS) continue;
      c = cur[dim];
      d = goal[dim];
      if (c == d) continue;
      span = (d > c) ? d - c : c - d;
      ring = wrap_dims[dim];
      eff = ring_size[dim];
      if (ring) begin
        if (eff < 1) eff = 1;
        if (eff > MAX_DIM_SIZE) eff = MAX_DIM_SIZE;
        // A coordinate off the ring leaves this dimension alone.
        if (c >= eff || d >= eff) continue;
        if (span * 2 > eff) begin
          steps = eff - span;
          plus = (d < c);
        end else if (span * 2 < eff) begin
          steps = span;
          plus = (d > c);
        end else begin
          // Half-way round either way: parity of the current coordinate decides.
          steps = span;
          plus = (c % 2) == 0;
        end
      end else begin
        steps = span;
        plus = (d > c);
      end
      repeat (steps) begin
        if (ring) c = plus ? (c + 1) % eff : (c + eff - 1) % eff;
        else c = plus ? c + 1 : c - 1;
        cur[dim] = 3'(c);
        if (held) hop_q.push_back(beat);
        count++;
        beat.hop_number = 6'(count);
        beat.hop_dim    = 3'(dim);
        beat.at_a       = cur[0];
        beat.at_b       = cur[1];
        beat.at_c       = cur[2];
        beat.at_d       = cur[3];
        beat.at_e       = cur[4];
        beat.at_t       = req.dst_t;
        beat.last_hop   = 1'b0;
        held = 1;
      end
    end
    if (held) begin
      beat.last_hop = 1'b1;
      hop_q.push_back(beat);
    end
  endfunction

  task automatic note_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    tdor_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_DIMS; k++) ring_size[k] = SIZE_RESET;
      wrap_dims = '0;
      route_order = ORDER_RESET;
      hop_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_A, REG_SIZE_B, REG_SIZE_C, REG_SIZE_D, REG_SIZE_E:
            ring_size[cfg_index] = cfg_data[SIZE_W-1:0];
          REG_WRAP_MASK:   wrap_dims = cfg_data[NUM_DIMS-1:0];
          REG_ROUTE_ORDER: route_order = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (hop_q.size() == 0) begin
          $display("%0t: unexpected hop beat, expected none, got %h", $time, out_data);
          fails++;
        end else begin
          want = hop_q.pop_front();
          note_field("hop_number", want.hop_number, out_data.hop_number);
          note_field("hop_dim", want.hop_dim, out_data.hop_dim);
          note_field("at_a", want.at_a, out_data.at_a);
          note_field("at_b", want.at_b, out_data.at_b);
          note_field("at_c", want.at_c, out_data.at_c);
          note_field("at_d", want.at_d, out_data.at_d);
          note_field("at_e", want.at_e, out_data.at_e);
          note_field("at_t", want.at_t, out_data.at_t);
          note_field("last_hop", want.last_hop, out_data.last_hop);
        end
      end
      if (in_valid && !in_stall) plan_route(in_data);
    end
    pending_hops <= hop_q.size();
    fail_count <= fails;
  end

endmodule

// File: tb/torus_dimension_order_route_tb.sv
`timescale 1ns / 1ps
// Top of the route walker testbench: clock, reset, route and register stimulus,
// random output stalls, watchdog and verdict. Depends on tdor_pkg, the block
// and tdor_hop_check.
module torus_dimension_order_route_tb;
  import tdor_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int ROUTES_PER_PHASE = 30;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tdor_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tdor_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ORDER_W-1:0] cfg_data = '0;

  int pending_hops, fail_count;
  bit idle_on = 1'b0;
  int stall_left = 0;
  int quiet = 0;
  logic [NUM_DIMS-1:0][SIZE_W-1:0] sz_set = {NUM_DIMS{SIZE_RESET}};
  logic [NUM_DIMS-1:0] wrap_set = '0;

  torus_dimension_order_route dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tdor_hop_check hop_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending_hops(pending_hops), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Output back-pressure comes in bursts of random length while idling is on.
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Waits for every predicted hop, then lets a route with no hops finish too.
  task automatic drain();
    do @(posedge clk); while (pending_hops != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no extra edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ORDER_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setup(logic [NUM_DIMS-1:0][SIZE_W-1:0] sizes,
                             logic [NUM_DIMS-1:0] wraps, logic [ORDER_W-1:0] order,
                             bit spare);
    drain();
    for (int k = 0; k < NUM_DIMS; k++)
      write_reg(tdor_reg_t'(int'(REG_SIZE_A) + k), {11'($urandom), sizes[k]});
    write_reg(REG_WRAP_MASK, {10'($urandom), wraps});
    write_reg(REG_ROUTE_ORDER, order);
    if (spare) write_reg(REG_SPARE, 15'($urandom));
    cfg_valid <= 1'b0;
    sz_set = sizes;
    wrap_set = wraps;
  endtask

  task automatic random_setup();
    logic [NUM_DIMS-1:0][SIZE_W-1:0] sizes;
    logic [ORDER_W-1:0] order;
    int perm [ORDER_SLOTS];
    int j, tmp, pick;
    for (int k = 0; k < NUM_DIMS; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) sizes[k] = 4'd0;
      else if (pick == 1) sizes[k] = 4'($urandom_range(9, 15));
      else sizes[k] = 4'($urandom_range(1, 8));
    end
    if ($urandom_range(0, 4) == 0) begin
      order = 15'($urandom);
    end else begin
      for (int k = 0; k < ORDER_SLOTS; k++) perm[k] = k;
      for (int k = ORDER_SLOTS - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = perm[k];
        perm[k] = perm[j];
        perm[j] = tmp;
      end
      for (int k = 0; k < ORDER_SLOTS; k++) order[3*k +: 3] = 3'(perm[k]);
    end
    apply_setup(sizes, 5'($urandom), order, $urandom_range(0, 3) == 0);
  endtask

  // Coordinates mostly stay on the configured rings so that hops happen.
  function automatic tdor_in_t random_route();
    logic [COORD_W-1:0] s [NUM_DIMS];
    logic [COORD_W-1:0] d [NUM_DIMS];
    int eff;
    bit same;
    same = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < NUM_DIMS; k++) begin
      eff = MAX_DIM_SIZE;
      if (wrap_set[k] && $urandom_range(0, 9) != 0) begin
        eff = sz_set[k];
        if (eff < 1) eff = 1;
        if (eff > MAX_DIM_SIZE) eff = MAX_DIM_SIZE;
      end
      s[k] = 3'($urandom_range(0, eff - 1));
      d[k] = same ? s[k] : 3'($urandom_range(0, eff - 1));
    end
    return {s[0], s[1], s[2], s[3], s[4], d[0], d[1], d[2], d[3], d[4],
            6'($urandom_range(0, 63))};
  endfunction

  task automatic push_route(tdor_in_t req, bit hold);
    if (hold) begin
      in_valid <= 1'b0;
      drain();
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    idle_on <= 1'b1;
    @(posedge clk);

    // Reset settings: every dimension a mesh, order A to E.
    push_route({15'o00000, 15'o00000, 6'd0}, 0);
    push_route({15'o00000, 15'o77777, 6'd63}, 0);
    push_route({15'o77777, 15'o00000, 6'd0}, 0);
    push_route({15'o70707, 15'o07070, 6'd21}, 0);
    in_valid <= 1'b0;

    // Full torus of eight per ring, routed E to A: ties and short ways round.
    apply_setup(20'h88888, 5'b11111, 15'o01234, 0);
    push_route({15'o00000, 15'o44444, 6'd5}, 0);
    push_route({15'o11111, 15'o55555, 6'd6}, 0);
    push_route({15'o00000, 15'o77777, 6'd7}, 0);
    push_route({15'o76543, 15'o01234, 6'd63}, 0);
    push_route({15'o33333, 15'o33333, 6'd1}, 0);
    in_valid <= 1'b0;

    // Sizes E=8 D=3 C=5 B=15 A=0, D a mesh; order C, bad, C again, B, bad,
    // so A, D and E are never routed.
    apply_setup(20'h835F0, 5'b10111, 15'o51272, 1);
    push_route({15'o00000, 15'o07000, 6'd9}, 0);
    push_route({15'o00600, 15'o00100, 6'd10}, 0);
    push_route({15'o00100, 15'o00400, 6'd11}, 0);
    push_route({15'o12345, 15'o04202, 6'd13}, 0);
    in_valid <= 1'b0;

    // Every slot names A.
    apply_setup(20'h11111, 5'b00000, 15'o00000, 0);
    push_route({15'o70000, 15'o07777, 6'd14}, 0);
    push_route({15'o34567, 15'o12345, 6'd15}, 0);
    in_valid <= 1'b0;

    // Every slot out of range: nothing is ever routed.
    apply_setup(20'hFFFFF, 5'b11111, 15'o77777, 0);
    push_route({15'o01234, 15'o76543, 6'd16}, 0);
    in_valid <= 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_setup();
      idle_on <= (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < ROUTES_PER_PHASE; i++)
        push_route(random_route(), $urandom_range(0, 24) == 0);
      in_valid <= 1'b0;
    end

    drain();
    if (fail_count == 0 && pending_hops == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
